>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; the including scope provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lmsd_pkg.sv
// Package for the LED matrix scan driver: panel geometry, word types, op codes, command type.
// No dependencies.
`timescale 1ns / 1ps
package lmsd_pkg;

  // geometry is fixed by the word field widths
  localparam int ROWS   = 16;
  localparam int COLS   = 16;
  localparam int PANELS = 2;

  localparam logic [2:0] OP_ON     = 3'd0;
  localparam logic [2:0] OP_OFF    = 3'd1;
  localparam logic [2:0] OP_TOGGLE = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_SCAN   = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic       panel;
    logic [3:0] pixel_row;
    logic [3:0] pixel_col;
  } in_item_t;

  typedef struct packed {
    logic       serial_bit;
    logic       out_panel;
    logic [3:0] row_address;
    logic       latch_last;
  } out_item_t;

  typedef enum logic [2:0] {
    K_ON,
    K_OFF,
    K_TOGGLE,
    K_CLEAR,
    K_SCAN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       panel;
    logic [3:0] pixel_row;
    logic [3:0] pixel_col;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

>>> hw/rtl/lmsd_front.sv
// Front end: accepts input words, drops ignored ones, registers a command.
// Depends on lmsd_pkg.
`timescale 1ns / 1ps
module lmsd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lmsd_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              push,
  output lmsd_pkg::cmd_t    cmd
);
  import lmsd_pkg::*;

  logic      cmd_valid_r;
  cmd_t      cmd_r;
  cmd_t      dec;
  logic      keep;
  logic      pix_ok;

  assign in_stall = cmd_valid_r && q_full;
  assign push     = cmd_valid_r && !q_full;
  assign cmd      = cmd_r;

  always_comb begin
    pix_ok        = (int'(in_item.pixel_row) < ROWS) && (int'(in_item.pixel_col) < COLS);
    dec.panel     = in_item.panel;
    dec.pixel_row = in_item.pixel_row;
    dec.pixel_col = in_item.pixel_col;
    dec.kind      = K_SCAN;
    keep          = 1'b0;
    case (in_item.op)
      OP_ON: begin
        dec.kind = K_ON;
        keep     = pix_ok;
      end
      OP_OFF: begin
        dec.kind = K_OFF;
        keep     = pix_ok;
      end
      OP_TOGGLE: begin
        dec.kind = K_TOGGLE;
        keep     = pix_ok;
      end
      OP_CLEAR: begin
        dec.kind = K_CLEAR;
        keep     = 1'b1;
      end
      OP_SCAN: begin
        dec.kind = K_SCAN;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
    if (int'(in_item.panel) >= PANELS) keep = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall && keep) begin
        cmd_valid_r <= 1'b1;
        cmd_r       <= dec;
      end else if (push) begin
        cmd_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/lmsd_queue.sv
// Two-entry command queue between front and back end.
// Depends on lmsd_pkg.
`timescale 1ns / 1ps
module lmsd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lmsd_pkg::cmd_t     push_cmd,
  input  logic               pop,
  output lmsd_pkg::q_status_t status,
  output lmsd_pkg::cmd_t     head
);
  import lmsd_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign status.valid = (count_r != 2'd0);
  assign status.full  = (count_r == 2'd2);
  assign head         = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        entry_r[wr_ptr_r] <= push_cmd;
        wr_ptr_r          <= ~wr_ptr_r;
      end
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop) count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule

>>> hw/rtl/lmsd_back.sv
// Back end: frame memory (one word per panel column), scan counters, bit shifter.
// Depends on lmsd_pkg.
`timescale 1ns / 1ps
module lmsd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lmsd_pkg::q_status_t q_status,
  input  lmsd_pkg::cmd_t      q_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output lmsd_pkg::out_item_t out_item
);
  import lmsd_pkg::*;

  localparam int Words = PANELS * COLS;
  localparam int AW    = $clog2(Words);
  localparam int CW    = $clog2(ROWS);

  typedef enum logic [1:0] {ST_IDLE, ST_MOD, ST_LOAD, ST_SHIFT} state_t;

  state_t          state_r;
  cmd_t            cmd_r;
  logic [AW-1:0]   addr_r;
  logic [3:0]      row_addr_r;
  logic [ROWS-1:0] mem [Words];
  logic [ROWS-1:0] rd_data_r;
  logic [Words-1:0] valid_r;
  logic [3:0]      scan_row_r [PANELS];
  logic [ROWS-1:0] sh_r;
  logic [CW-1:0]   cnt_r;
  logic            out_valid_r;
  out_item_t       out_item_r;

  logic [3:0]      r_cur;
  logic [AW-1:0]   rd_addr;
  logic [ROWS-1:0] word_eff;
  logic [ROWS-1:0] mask;
  logic [ROWS-1:0] mod_word;
  logic [Words-1:0] clr_mask;
  logic            out_free;
  logic [3:0]      r_next;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign pop       = (state_r == ST_IDLE) && q_status.valid;
  assign out_free  = !out_valid_r || !out_stall;
  assign word_eff  = valid_r[addr_r] ? rd_data_r : '1;
  assign mask      = {{(ROWS-1){1'b0}}, 1'b1} << cmd_r.pixel_row;
  assign r_next    = (int'(row_addr_r) + 1 == COLS) ? 4'd0 : row_addr_r + 4'd1;

  always_comb begin
    r_cur = '0;
    for (int p = 0; p < PANELS; p++) begin
      if (int'(q_cmd.panel) == p) r_cur = scan_row_r[p];
    end
    if (q_cmd.kind == K_SCAN)
      rd_addr = AW'(int'(q_cmd.panel) * COLS + COLS - 1 - int'(r_cur));
    else
      rd_addr = AW'(int'(q_cmd.panel) * COLS + int'(q_cmd.pixel_col));
    for (int a = 0; a < Words; a++) begin
      clr_mask[a] = (a / COLS == int'(q_cmd.panel));
    end
    case (cmd_r.kind)
      K_ON:    mod_word = word_eff & ~mask;
      K_OFF:   mod_word = word_eff | mask;
      default: mod_word = word_eff ^ mask;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MOD) mem[addr_r] <= mod_word;
    if (state_r == ST_IDLE) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < PANELS; p++) scan_row_r[p] <= 4'd0;
    end else begin
      if (!out_stall && state_r != ST_SHIFT) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_status.valid) begin
            cmd_r      <= q_cmd;
            addr_r     <= rd_addr;
            row_addr_r <= r_cur;
            case (q_cmd.kind)
              K_CLEAR: valid_r <= valid_r & ~clr_mask;
              K_SCAN:  state_r <= ST_LOAD;
              default: state_r <= ST_MOD;
            endcase
          end
        end
        ST_MOD: begin
          valid_r[addr_r] <= 1'b1;
          state_r         <= ST_IDLE;
        end
        ST_LOAD: begin
          sh_r    <= word_eff;
          cnt_r   <= CW'(ROWS - 1);
          state_r <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (out_free) begin
            out_valid_r             <= 1'b1;
            out_item_r.serial_bit   <= sh_r[ROWS-1];
            out_item_r.out_panel    <= cmd_r.panel;
            out_item_r.row_address  <= row_addr_r;
            out_item_r.latch_last   <= (cnt_r == '0);
            sh_r                    <= sh_r << 1;
            cnt_r                   <= cnt_r - 1'b1;
            if (cnt_r == '0) begin
              state_r <= ST_IDLE;
              for (int p = 0; p < PANELS; p++) begin
                if (int'(cmd_r.panel) == p) scan_row_r[p] <= r_next;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/led_matrix_scan_driver_top.sv
// Top level of the LED matrix row-scan driver: front end, command queue, back end.
// Depends on lmsd_pkg, lmsd_front, lmsd_queue, lmsd_back.
//
// Frame stores are active low (1 = LED off) and hold one ROWS-bit word per panel
// column in a single-port memory; a per-word valid flag stands in for the all-off
// reset and for panel clear, so there is no clearing pass after reset. A pixel
// on/off/toggle in the back end is a memory read, then a write back; a panel
// clear is done in the idle state alone, and a row scan is one read, one
// load, then ROWS serial words at one per cycle while out_stall is low. Words of
// one scan come MSB row first; the last carries latch_last, after which that
// panel's row counter advances. A two-entry queue lets the front keep accepting
// commands during a scan; out-of-range and unknown commands are dropped at entry.
`timescale 1ns / 1ps
module led_matrix_scan_driver_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lmsd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lmsd_pkg::out_item_t out_item
);
  import lmsd_pkg::*;

  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  q_status_t q_status;
  cmd_t      head;

  lmsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_status.full),
    .push     (push),
    .cmd      (push_cmd)
  );

  lmsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .status   (q_status),
    .head     (head)
  );

  lmsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_cmd     (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> hw/rtl/lmsd_checker.sv
// Port-level checker for the scan driver, bound to the top level.
// Depends on lmsd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lmsd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input lmsd_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input lmsd_pkg::out_item_t out_item
);

  `ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_item), "stalled in word changed")

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled out word changed")

  `ASSERT_NEXT(a_scan_burst, out_valid && !out_stall && !out_item.latch_last, out_valid && out_item.out_panel == $past(out_item.out_panel) && out_item.row_address == $past(out_item.row_address), "scan words broke up")

  `ASSERT_IMPLY(a_first_not_last, $rose(out_valid), !out_item.latch_last, "scan started on latch word")

endmodule

bind led_matrix_scan_driver_top lmsd_checker u_lmsd_checker (.*);
